/* rtl/osa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package osa_pkg;

	localparam int MAX_LEN   = 64;
	localparam int CNT_W     = $clog2(MAX_LEN + 1);
	localparam int IDX_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int VAL_W     = CNT_W;
	localparam int SYM_W     = 8;
	localparam int DIST_W    = 7;
	localparam int DIST_MAX  = 127;
	localparam int MAT_DEPTH = 3 * MAX_LEN;
	localparam int MAT_AW    = $clog2(MAT_DEPTH);

	typedef enum logic [1:0] {
		OP_APPEND_FIRST  = 2'd0,
		OP_APPEND_SECOND = 2'd1,
		OP_COMPUTE       = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROW_RD,
		ST_ROW_INIT,
		ST_CELL_RD,
		ST_CELL_WR,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]       operation;
		logic [SYM_W-1:0] symbol;
	} request_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              overflow;
	} result_t;

	typedef struct packed {
		logic append;
		logic comp_init;
		logic row_init;
		logic cell_write;
		logic row_next;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic n1_zero;
		logic n2_zero;
		logic j_last;
		logic i_last;
	} status_t;

	function automatic logic [MAT_AW-1:0] row_base(input logic [1:0] sel);
		logic [MAT_AW-1:0] base;
		unique case (sel)
			2'd1:    base = MAT_AW'(MAX_LEN);
			2'd2:    base = MAT_AW'(2 * MAX_LEN);
			default: base = '0;
		endcase
		return base;
	endfunction

	function automatic logic [DIST_W-1:0] sat_dist(input logic [VAL_W-1:0] v);
		logic [DIST_W-1:0] d;
		if (32'(v) > 32'(DIST_MAX)) begin
			d = DIST_W'(DIST_MAX);
		end else begin
			d = DIST_W'(v);
		end
		return d;
	endfunction

endpackage

`default_nettype wire

/* rtl/osa_edit_distance.sv */
// Channel   Signals                  Transfer rule
// request   start, busy, request     start high while busy low at a rising edge
// result    done, result             done high for one cycle, always taken
//
// Appends keep busy low. Compute goes straight to the done state when a string
// is empty; else each cell reads the matrix RAM and string RAM (registered read)
// and writes in the following cycle.
// Reset clears lengths, overflow and controller state; the RAMs need no clearing.
// The result cannot be stalled; done marks the single cycle it is valid.
`timescale 1ns / 1ps
`default_nettype none

module osa_edit_distance (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output      logic             busy,
	input  wire osa_pkg::request_t request,
	output      logic             done,
	output      osa_pkg::result_t  result
);

	osa_pkg::cmd_t    cmd;
	osa_pkg::status_t status;

	osa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (request.operation),
		.status    (status),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done)
	);

	osa_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.status  (status),
		.result  (result)
	);

endmodule

`default_nettype wire

/* rtl/osa_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module osa_ram #(
	parameter  int WIDTH = 8,
	parameter  int DEPTH = 64,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr_a,
	output      logic [WIDTH-1:0] rdata_a,
	input  wire logic [AW-1:0]    raddr_b,
	output      logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

`default_nettype wire

/* rtl/osa_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module osa_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [1:0]      operation,
	input  wire osa_pkg::status_t status,
	output      osa_pkg::cmd_t    cmd,
	output      logic            busy,
	output      logic            done
);

	osa_pkg::state_t state_q;
	osa_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= osa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		done    = 1'b0;
		unique case (state_q)
			osa_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					priority if (operation == osa_pkg::OP_APPEND_FIRST ||
							operation == osa_pkg::OP_APPEND_SECOND) begin
						cmd.append = 1'b1;
					end else if (operation == osa_pkg::OP_COMPUTE) begin
						if (status.n1_zero || status.n2_zero) begin
							state_d = osa_pkg::ST_DONE;
						end else begin
							cmd.comp_init = 1'b1;
							state_d       = osa_pkg::ST_ROW_RD;
						end
					end else begin
						state_d = osa_pkg::ST_IDLE;
					end
				end
			end
			osa_pkg::ST_ROW_RD: begin
				state_d = osa_pkg::ST_ROW_INIT;
			end
			osa_pkg::ST_ROW_INIT: begin
				cmd.row_init = 1'b1;
				state_d      = osa_pkg::ST_CELL_RD;
			end
			osa_pkg::ST_CELL_RD: begin
				state_d = osa_pkg::ST_CELL_WR;
			end
			osa_pkg::ST_CELL_WR: begin
				cmd.cell_write = 1'b1;
				if (!status.j_last) begin
					state_d = osa_pkg::ST_CELL_RD;
				end else if (status.i_last) begin
					state_d = osa_pkg::ST_DONE;
				end else begin
					cmd.row_next = 1'b1;
					state_d      = osa_pkg::ST_ROW_RD;
				end
			end
			osa_pkg::ST_DONE: begin
				cmd.finish = 1'b1;
				done       = 1'b1;
				state_d    = osa_pkg::ST_IDLE;
			end
			default: begin
				state_d = osa_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/osa_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module osa_dp (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire osa_pkg::request_t request,
	input  wire osa_pkg::cmd_t     cmd,
	output      osa_pkg::status_t  status,
	output      osa_pkg::result_t  result
);

	localparam int CW = osa_pkg::CNT_W;
	localparam int IW = osa_pkg::IDX_W;
	localparam int VW = osa_pkg::VAL_W;
	localparam int SW = osa_pkg::SYM_W;
	localparam int AW = osa_pkg::MAT_AW;

	logic [CW-1:0] len1_q, len2_q, i_q, j_q;
	logic          ovf_q;
	logic [1:0]    cur_sel_q, prev_sel_q, prev2_sel_q;
	logic [SW-1:0] a_q, a2_q;
	logic [VW-1:0] left_q, diag_q;

	logic          we1, we2;
	logic [SW-1:0] s1_rd_a, s1_rd_b, s2_rd_a, s2_rd_b;
	logic [VW-1:0] mat_rd_a, mat_rd_b;
	logic [IW-1:0] col, col2;
	logic [AW-1:0] mat_waddr, mat_raddr_a, mat_raddr_b;

	logic [VW-1:0] up, p2, v;
	logic [VW:0]   c_up, c_left, c_diag, c_p2, m1, m2, m3;
	logic          swap_ok;

	assign we1 = cmd.append && request.operation == osa_pkg::OP_APPEND_FIRST &&
			32'(len1_q) < osa_pkg::MAX_LEN;
	assign we2 = cmd.append && request.operation == osa_pkg::OP_APPEND_SECOND &&
			32'(len2_q) < osa_pkg::MAX_LEN;

	assign col  = IW'(j_q - CW'(1));
	assign col2 = IW'(j_q - CW'(3));

	assign mat_waddr   = osa_pkg::row_base(cur_sel_q) + AW'(col);
	assign mat_raddr_a = osa_pkg::row_base(prev_sel_q) + AW'(col);
	assign mat_raddr_b = osa_pkg::row_base(prev2_sel_q) + AW'(col2);

	osa_ram #(.WIDTH(SW), .DEPTH(osa_pkg::MAX_LEN)) u_first (
		.clk     (clk),
		.we      (we1),
		.waddr   (IW'(len1_q)),
		.wdata   (request.symbol),
		.raddr_a (IW'(i_q - CW'(1))),
		.rdata_a (s1_rd_a),
		.raddr_b (IW'(i_q - CW'(2))),
		.rdata_b (s1_rd_b)
	);

	osa_ram #(.WIDTH(SW), .DEPTH(osa_pkg::MAX_LEN)) u_second (
		.clk     (clk),
		.we      (we2),
		.waddr   (IW'(len2_q)),
		.wdata   (request.symbol),
		.raddr_a (col),
		.rdata_a (s2_rd_a),
		.raddr_b (IW'(j_q - CW'(2))),
		.rdata_b (s2_rd_b)
	);

	osa_ram #(.WIDTH(VW), .DEPTH(osa_pkg::MAT_DEPTH)) u_matrix (
		.clk     (clk),
		.we      (cmd.cell_write),
		.waddr   (mat_waddr),
		.wdata   (v),
		.raddr_a (mat_raddr_a),
		.rdata_a (mat_rd_a),
		.raddr_b (mat_raddr_b),
		.rdata_b (mat_rd_b)
	);

	always_comb begin
		up = (i_q == CW'(1)) ? VW'(j_q) : mat_rd_a;
		priority if (j_q == CW'(2)) begin
			p2 = VW'(i_q - CW'(2));
		end else if (i_q == CW'(2)) begin
			p2 = VW'(j_q - CW'(2));
		end else begin
			p2 = mat_rd_b;
		end
		swap_ok = (i_q > CW'(1)) && (j_q > CW'(1)) &&
				(a_q == s2_rd_b) && (a2_q == s2_rd_a);
		c_up   = {1'b0, up} + (VW+1)'(1);
		c_left = {1'b0, left_q} + (VW+1)'(1);
		c_diag = {1'b0, diag_q} + (VW+1)'(a_q != s2_rd_a);
		c_p2   = {1'b0, p2} + (VW+1)'(1);
		m1 = (c_up < c_left) ? c_up : c_left;
		m2 = (c_diag < m1) ? c_diag : m1;
		m3 = (swap_ok && c_p2 < m2) ? c_p2 : m2;
		v  = VW'(m3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len1_q      <= '0;
			len2_q      <= '0;
			ovf_q       <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			cur_sel_q   <= 2'd1;
			prev_sel_q  <= 2'd0;
			prev2_sel_q <= 2'd2;
		end else begin
			if (cmd.append) begin
				priority if (we1) begin
					len1_q <= len1_q + CW'(1);
				end else if (we2) begin
					len2_q <= len2_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.comp_init) begin
				i_q         <= CW'(1);
				cur_sel_q   <= 2'd1;
				prev_sel_q  <= 2'd0;
				prev2_sel_q <= 2'd2;
			end
			if (cmd.row_init) begin
				j_q <= CW'(1);
			end else if (cmd.cell_write) begin
				j_q <= j_q + CW'(1);
			end
			if (cmd.row_next) begin
				i_q         <= i_q + CW'(1);
				cur_sel_q   <= prev2_sel_q;
				prev_sel_q  <= cur_sel_q;
				prev2_sel_q <= prev_sel_q;
			end
			if (cmd.finish) begin
				len1_q <= '0;
				len2_q <= '0;
				ovf_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.row_init) begin
			a_q    <= s1_rd_a;
			a2_q   <= s1_rd_b;
			left_q <= VW'(i_q);
			diag_q <= VW'(i_q - CW'(1));
		end else if (cmd.cell_write) begin
			left_q <= v;
			diag_q <= up;
		end
	end

	assign status.n1_zero = (len1_q == '0);
	assign status.n2_zero = (len2_q == '0);
	assign status.j_last  = (j_q == len2_q);
	assign status.i_last  = (i_q == len1_q);

	always_comb begin
		priority if (len1_q == '0) begin
			result.distance = osa_pkg::sat_dist(VW'(len2_q));
		end else if (len2_q == '0) begin
			result.distance = osa_pkg::sat_dist(VW'(len1_q));
		end else begin
			result.distance = osa_pkg::sat_dist(left_q);
		end
		result.overflow = ovf_q;
	end

endmodule

`default_nettype wire
